>>> sv/gaussian5x5_image_filter_unit_defines.svh
// Assertion macros for the 5x5 Gaussian filter.
`ifndef GAUSSIAN5X5_IMAGE_FILTER_UNIT_DEFINES_SVH
`define GAUSSIAN5X5_IMAGE_FILTER_UNIT_DEFINES_SVH
// Assert a property sampled on clk, disabled in reset.
`define G5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property that must also hold while reset is active.
`define G5_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/g5_pkg.sv
// Shared constants of the 5x5 Gaussian filter.
package g5_pkg;
    localparam int MAX_SIZE_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SIZE_BITS       = 11;
    localparam int OUT_BITS        = 16;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd64;
    localparam int QDEPTH          = 4;
    localparam logic KIND_PIXEL    = 1'b0;
    localparam logic KIND_FLUSH    = 1'b1;
endpackage

>>> sv/g5_stream_if.sv
// Valid/ready channel with a filter payload.
interface g5_stream_if #(parameter int DATA_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [DATA_BITS-1:0] data;
    logic                 last;
    modport source (output valid, kind, data, last, input ready);
    modport sink (input valid, kind, data, last, output ready);
endinterface

>>> sv/g5_front.sv
// Front end: position tracking, line store, column vector build.
module g5_front #(
    parameter int MAX_SIZE    = g5_pkg::MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = g5_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [g5_pkg::SIZE_BITS-1:0]          size_eff,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_kind,
    input  logic signed [SAMPLE_BITS-1:0]         in_pixel,
    output logic                                  col_valid,
    input  logic                                  col_ready,
    output logic signed [4:0][SAMPLE_BITS-1:0]    col_data,
    output logic                                  col_emit,
    output logic                                  col_end
);
    localparam int CB = $clog2(MAX_SIZE);
    localparam int RB = g5_pkg::SIZE_BITS + 1;

    logic [CB-1:0] col_reg;
    logic [RB-1:0] row_reg;
    // stage 1 registers
    logic                       s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_cur_reg;
    logic [4:0]                 s1_self_reg;
    logic [4:0][1:0]            s1_sel_reg;
    logic                       s1_emit_reg, s1_end_reg;
    logic [SAMPLE_BITS-1:0]     rd_reg [4];

    logic advance, acc, in_img, fe, em;
    logic signed [RB:0] r_s, s_s;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic [4:0] self_w;
    logic [4:0][1:0] sel_w;
    logic signed [RB:0] j;

    assign advance = !s1_valid_reg || col_ready;
    assign in_ready = advance;
    assign acc = in_valid && in_ready;
    assign r_s = {1'b0, row_reg};
    assign s_s = {{(RB+1-g5_pkg::SIZE_BITS){1'b0}}, size_eff};
    assign in_img = r_s < s_s;
    assign cur = (in_kind == g5_pkg::KIND_PIXEL && in_img) ? in_pixel : '0;
    assign em = (row_reg > RB'(2)) || (row_reg == RB'(2) && col_reg >= CB'(2));
    assign fe = (r_s > s_s + (RB+1)'(2)) || (r_s == s_s + (RB+1)'(2) && col_reg >= CB'(1));

    always_comb
    begin
        j = '0;
        for (int d = 0; d < 5; d++)
        begin
            j = r_s - (RB+1)'(4) + (RB+1)'(d);
            if (j < 0) j = '0;
            if (j > s_s - (RB+1)'(1)) j = s_s - (RB+1)'(1);
            self_w[d] = (j == r_s);
            sel_w[d] = j[1:0];
        end
    end

    // one bank per row slot: one read and at most one write per item
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [SAMPLE_BITS-1:0] mem [MAX_SIZE];
        always_ff @(posedge clk)
        begin
            if (acc)
            begin
                rd_reg[b] <= mem[col_reg];
                if (in_img && row_reg[1:0] == 2'(b))
                    mem[col_reg] <= cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cur_reg  <= cur;
            s1_self_reg <= self_w;
            s1_sel_reg  <= sel_w;
            s1_emit_reg <= em;
            s1_end_reg  <= fe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance) s1_valid_reg <= acc;
            if (acc)
            begin
                if (fe)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if ({1'b0, col_reg} + 1'b1 >= (CB+1)'(size_eff))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int d = 0; d < 5; d++)
            col_data[d] = s1_self_reg[d] ? s1_cur_reg : rd_reg[s1_sel_reg[d]];
    end
    assign col_valid = s1_valid_reg;
    assign col_emit  = s1_emit_reg;
    assign col_end   = s1_end_reg;
endmodule

>>> sv/g5_queue.sv
// Short FIFO between front end and filter core.
module g5_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int D  = g5_pkg::QDEPTH;
    localparam int AB = $clog2(D);
    logic [W-1:0] q_reg [D];
    logic [AB-1:0] wp_reg, rp_reg;
    logic [AB:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (AB+1)'(D);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = q_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr) q_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AB+1)'(wr) - (AB+1)'(rd);
        end
    end
endmodule

>>> sv/g5_core.sv
// Back end: 5x5 window, border clamp, weighted sum, rounding.
`include "gaussian5x5_image_filter_unit_defines.svh"
module g5_core #(
    parameter int MAX_SIZE    = g5_pkg::MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = g5_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [g5_pkg::SIZE_BITS-1:0]          size_eff,
    input  logic                                  col_valid,
    output logic                                  col_ready,
    input  logic signed [4:0][SAMPLE_BITS-1:0]    col_data,
    input  logic                                  col_emit,
    input  logic                                  col_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [g5_pkg::OUT_BITS-1:0]           out_filtered,
    output logic                                  out_last
);
    localparam int VB = SAMPLE_BITS + 4;  // vertical sum, weight 16
    localparam int HB = SAMPLE_BITS + 9;  // full sum, weight 256
    localparam int OB = g5_pkg::OUT_BITS;
    localparam int CB = $clog2(MAX_SIZE) + 1;

    logic signed [4:0][VB-1:0] win_reg;   // vertical sums, index 4 newest
    logic [CB-1:0] oc_reg;
    logic s1_valid_reg, s1_last_reg;
    logic signed [4:0][VB-1:0] s1_tap_reg;
    logic o_valid_reg, o_last_reg;
    logic [OB-1:0] o_data_reg;

    logic adv1, adv2, take;
    logic signed [VB-1:0] cx [5];
    logic signed [HB-1:0] tx [5];
    logic signed [VB-1:0] vs;
    logic signed [4:0][VB-1:0] nwin;
    logic signed [4:0][VB-1:0] taps;
    logic signed [CB:0] cc, cl, p, s_s;
    logic signed [HB-1:0] sum, t;
    logic signed [HB-9:0] q;

    assign adv2 = !o_valid_reg || out_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign col_ready = adv1;
    assign take = col_valid && adv1;
    assign s_s = (CB+1)'(size_eff);

    always_comb
    begin
        // packed elements are unsigned, so sign-extend each one explicitly
        for (int d = 0; d < 5; d++)
            cx[d] = VB'($signed(col_data[d]));
        vs = cx[0] + (cx[1] <<< 2) + (cx[2] <<< 2) + (cx[2] <<< 1) + (cx[3] <<< 2) + cx[4];
        nwin = {vs, win_reg[4:1]};
        for (int k = 0; k < 5; k++)
        begin
            cc = $signed({1'b0, oc_reg}) - (CB+1)'(2) + (CB+1)'(k);
            cl = cc;
            if (cl < 0) cl = '0;
            if (cl > s_s - (CB+1)'(1)) cl = s_s - (CB+1)'(1);
            p = (CB+1)'(k) + cl - cc;
            if (p < 0) p = '0;
            if (p > 4) p = (CB+1)'(4);
            taps[k] = nwin[p[2:0]];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 5; k++)
            tx[k] = HB'($signed(s1_tap_reg[k]));
        sum = tx[0] + (tx[1] <<< 2) + (tx[2] <<< 2) + (tx[2] <<< 1) + (tx[3] <<< 2) + tx[4];
        t = sum + HB'(128);
        q = t[HB-1:8];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            win_reg <= nwin;
            s1_tap_reg <= taps;
            s1_last_reg <= col_end;
        end
        if (adv2 && s1_valid_reg)
        begin
            o_data_reg <= OB'(q);
            o_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= take && col_emit;
            if (adv2) o_valid_reg <= s1_valid_reg;
            if (take)
            begin
                if (col_end) oc_reg <= '0;
                else if (col_emit)
                    oc_reg <= ({1'b0, oc_reg} + 1'b1 >= s_s) ? '0 : oc_reg + 1'b1;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_filtered = o_data_reg;
    assign out_last = o_last_reg;

    `G5_ASSERT(a_hold, o_valid_reg && !out_ready |=> o_valid_reg && $stable(o_data_reg),
        "result changed while stalled")
    `G5_ASSERT(a_col, oc_reg < CB'(MAX_SIZE), "output column out of range")
    `G5_ASSERT(a_adv, s1_valid_reg && adv2 |=> o_valid_reg, "stage result lost")
    `G5_ASSERT_ALWAYS(a_rst, !rst_n |-> !out_valid, "result valid in reset")
endmodule

>>> sv/gaussian5x5_image_filter_unit.sv
// Top level of the 5x5 Gaussian filter.
// Takes one item per clock and gives one result per clock when the output
// side is ready; results for pixel p come out on the item at raster position
// p + 2*size + 2; after that item is accepted, a result passes through the
// line store read, queue, tap select, then the sum and round register.
// Send 2*size+2 flush items after a frame.
// Size is saturated to 5..MAX_SIZE.
module gaussian5x5_image_filter_unit #(
    parameter int MAX_SIZE    = g5_pkg::MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = g5_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [g5_pkg::SIZE_BITS-1:0] cfg_wdata,
    g5_stream_if.sink                    in_ch,
    g5_stream_if.source                  out_ch
);
    localparam int W = 5 * SAMPLE_BITS + 2;
    logic [g5_pkg::SIZE_BITS-1:0] size_reg, size_eff;
    logic fv, fr, qv, qr, fe, fen;
    logic signed [4:0][SAMPLE_BITS-1:0] fd, qd;
    logic qe, qn;
    logic [W-1:0] qo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= g5_pkg::SIZE_RESET;
        else if (cfg_we) size_reg <= cfg_wdata;
    end
    always_comb
    begin
        size_eff = size_reg;
        if (size_reg < g5_pkg::SIZE_BITS'(5)) size_eff = g5_pkg::SIZE_BITS'(5);
        if ({1'b0, size_reg} > (g5_pkg::SIZE_BITS+1)'(MAX_SIZE))
            size_eff = g5_pkg::SIZE_BITS'(MAX_SIZE);
    end

    g5_front #(.MAX_SIZE(MAX_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk, .rst_n, .size_eff,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
        .in_pixel(in_ch.data[SAMPLE_BITS-1:0]),
        .col_valid(fv), .col_ready(fr), .col_data(fd), .col_emit(fe), .col_end(fen));

    g5_queue #(.W(W)) u_queue (
        .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data({fe, fen, fd}),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qo));

    assign qe = qo[W-1];
    assign qn = qo[W-2];
    assign qd = qo[W-3:0];

    g5_core #(.MAX_SIZE(MAX_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_core (
        .clk, .rst_n, .size_eff,
        .col_valid(qv), .col_ready(qr), .col_data(qd), .col_emit(qe), .col_end(qn),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_filtered(out_ch.data), .out_last(out_ch.last));

    assign out_ch.kind = g5_pkg::KIND_PIXEL;
endmodule

>>> sim/gaussian5x5_image_filter_unit_tb.sv
// Self-checking testbench for the 5x5 Gaussian image filter unit.
`timescale 1ns / 1ps

module gaussian5x5_image_filter_unit_tb;

    localparam int MAXS = g5_pkg::MAX_SIZE_DEF;
    localparam int LIMIT_CYCLES = 100000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic [15:0] filtered;
        logic        last;
    } blur_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [g5_pkg::SIZE_BITS-1:0] cfg_wdata;

    g5_stream_if #(.DATA_BITS(16)) in_ch ();
    g5_stream_if #(.DATA_BITS(16)) out_ch ();

    gaussian5x5_image_filter_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    logic [g5_pkg::SIZE_BITS-1:0] size_reg;
    logic signed [15:0] line_mem [4*MAXS];
    logic signed [15:0] win [5][5];
    int col_in, row_in, col_out;
    blur_out_t blur_q[$];

    int errors;
    int cycles;
    bit quiet_tail;
    bit want_on;
    logic [15:0] want_val;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int eff_size();
        int s;
        s = size_reg;
        if (s < 5) s = 5;
        if (s > MAXS) s = MAXS;
        return s;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void blur_reset();
        size_reg = g5_pkg::SIZE_RESET;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        col_in = 0;
        row_in = 0;
        col_out = 0;
    endfunction

    // advances the filter model by one item, queues a result if one is due
    function automatic void blur_predict(pix_item_t it);
        int s, r, c, j, cc, p;
        logic signed [15:0] cur;
        logic signed [15:0] colv [5];
        longint sum, t, q;
        int w [5];
        bit emit, fend;
        blur_out_t res;
        w = '{1, 4, 6, 4, 1};
        s = eff_size();
        r = row_in;
        c = (col_in >= MAXS) ? MAXS - 1 : col_in;
        cur = (it.kind == g5_pkg::KIND_PIXEL && r < s) ? it.pixel : 16'sd0;
        for (int d = 0; d < 5; d++)
        begin
            j = clip(r - 4 + d, 0, s - 1);
            colv[d] = (j == r) ? cur : line_mem[(j & 3) * MAXS + c];
        end
        if (r < s) line_mem[(r & 3) * MAXS + c] = cur;
        for (int k = 0; k < 4; k++)
            for (int d = 0; d < 5; d++)
                win[k][d] = win[k+1][d];
        for (int d = 0; d < 5; d++) win[4][d] = colv[d];
        emit = (r > 2) || (r == 2 && c >= 2);
        fend = (r > s + 2) || (r == s + 2 && c >= 1);
        if (emit)
        begin
            sum = 0;
            for (int k = 0; k < 5; k++)
            begin
                cc = col_out - 2 + k;
                p = clip(k + (clip(cc, 0, s - 1) - cc), 0, 4);
                for (int d = 0; d < 5; d++)
                    sum += w[k] * w[d] * longint'(win[p][d]);
            end
            t = sum + 128;
            q = (t >= 0) ? t / 256 : -((-t + 255) / 256);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            res.filtered = q[15:0];
            res.last = fend;
            blur_q = {blur_q, res};
            col_out++;
            if (col_out >= s) col_out = 0;
        end
        if (fend)
        begin
            col_in = 0;
            row_in = 0;
            col_out = 0;
        end
        else
        begin
            col_in++;
            if (col_in >= s)
            begin
                col_in = 0;
                row_in++;
            end
        end
    endfunction

    // output side: random stalls, compare on accept
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (blur_q.size() == 0)
            begin
                $display("%0t: unexpected result filtered=%h last=%b", $time,
                         out_ch.data, out_ch.last);
                errors++;
            end
            else
            begin
                blur_out_t e;
                e = blur_q.pop_front();
                if (out_ch.data !== e.filtered)
                begin
                    $display("%0t: filtered expected %h actual %h", $time,
                             e.filtered, out_ch.data);
                    errors++;
                end
                if (out_ch.last !== e.last)
                begin
                    $display("%0t: last_of_frame expected %b actual %b", $time,
                             e.last, out_ch.last);
                    errors++;
                end
                if (want_on && out_ch.data !== want_val)
                begin
                    $display("%0t: flat frame expected %h actual %h", $time,
                             want_val, out_ch.data);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(pix_item_t it);
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind;
        in_ch.data <= it.pixel;
        in_ch.last <= 1'b0;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        blur_predict(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (blur_q.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(logic [g5_pkg::SIZE_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        size_reg = v;
    endtask

    function automatic logic [15:0] rand_pixel(int mode);
        case (mode)
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one full frame plus flush items; mostly well-formed, sometimes odd kinds
    task automatic run_frame(int mode, bit noisy);
        int s;
        pix_item_t it;
        s = eff_size();
        for (int i = 0; i < s * s + 2 * s + 2; i++)
        begin
            it.kind = (i < s * s) ? g5_pkg::KIND_PIXEL : g5_pkg::KIND_FLUSH;
            if (noisy && $urandom_range(0, 15) == 0) it.kind = ~it.kind;
            it.pixel = rand_pixel(mode);
            send_item(it);
        end
    endtask

    // directed table: flat frames give known results
    typedef struct {
        logic [g5_pkg::SIZE_BITS-1:0] size;
        logic [15:0]                  level;
        logic [15:0]                  want;
    } flat_row_t;

    flat_row_t flat_tab[6] = '{
        '{11'd5, 16'h7FFF, 16'h7FFF},
        '{11'd0, 16'h8000, 16'h8000},
        '{11'd5, 16'h0000, 16'h0000},
        '{11'd7, 16'h0100, 16'h0100},
        '{11'd9, 16'h0001, 16'h0001},
        '{11'd6, 16'hFFFF, 16'hFFFF}
    };

    initial
    begin
        pix_item_t it;
        int s, n;
        errors = 0;
        cycles = 0;
        quiet_tail = 1'b0;
        want_on = 1'b0;
        want_val = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = g5_pkg::KIND_PIXEL;
        in_ch.data = '0;
        in_ch.last = 1'b0;
        blur_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // a flat image must come back unchanged
        foreach (flat_tab[r])
        begin
            write_size(flat_tab[r].size);
            s = eff_size();
            want_val = flat_tab[r].want;
            want_on = 1'b1;
            for (int i = 0; i < s * s + 2 * s + 2; i++)
            begin
                it.kind = (i < s * s) ? g5_pkg::KIND_PIXEL : g5_pkg::KIND_FLUSH;
                it.pixel = flat_tab[r].level;
                send_item(it);
            end
            drain_results();
            want_on = 1'b0;
        end

        // random frames of small sizes
        n = 0;
        while (n < 1000)
        begin
            write_size(11'($urandom_range(5, 9)));
            s = eff_size();
            run_frame($urandom_range(0, 5), $urandom_range(0, 3) == 0);
            n += s * s + 2 * s + 2;
            drain_results();
        end

        quiet_tail = 1'b1;
        write_size(11'd5);
        run_frame(2, 1'b0);
        drain_results();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
